// File: rtl/core/sl_pkg.sv
// ----------------------------------------------------------------------------
// sl_pkg: shared definitions of the script lexer
// token codes, character codes, keyword table, scan modes and the result word
// ----------------------------------------------------------------------------
package sl_pkg;

  // default sizes
  localparam int MAX_WORD_DEF  = 16;
  localparam int LINE_BITS_DEF = 16;

  // fixed field widths
  localparam int CH_W    = 8;
  localparam int KIND_W  = 6;
  localparam int TLINE_W = 16;
  localparam int CFG_W   = 16;

  // result queue
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = 2;
  localparam int RQ_CNT_W = 3;

  // token kinds
  localparam logic [KIND_W-1:0] TK_EOF       = 6'd0;
  localparam logic [KIND_W-1:0] TK_BAD       = 6'd1;
  localparam logic [KIND_W-1:0] TK_IDENT     = 6'd2;
  localparam logic [KIND_W-1:0] TK_NUMBER    = 6'd3;
  localparam logic [KIND_W-1:0] TK_STRING    = 6'd4;
  localparam logic [KIND_W-1:0] TK_SET       = 6'd5;
  localparam logic [KIND_W-1:0] TK_FOR       = 6'd6;
  localparam logic [KIND_W-1:0] TK_IF        = 6'd7;
  localparam logic [KIND_W-1:0] TK_TO        = 6'd8;
  localparam logic [KIND_W-1:0] TK_NUM       = 6'd9;
  localparam logic [KIND_W-1:0] TK_STR       = 6'd10;
  localparam logic [KIND_W-1:0] TK_PRINT     = 6'd11;
  localparam logic [KIND_W-1:0] TK_PRINTLN   = 6'd12;
  localparam logic [KIND_W-1:0] TK_WAIT      = 6'd13;
  localparam logic [KIND_W-1:0] TK_CLEAR     = 6'd14;
  localparam logic [KIND_W-1:0] TK_REMOVE    = 6'd15;
  localparam logic [KIND_W-1:0] TK_LOAD_FILE = 6'd16;
  localparam logic [KIND_W-1:0] TK_READ      = 6'd17;
  localparam logic [KIND_W-1:0] TK_ENDPROG   = 6'd18;
  localparam logic [KIND_W-1:0] TK_EXECUTE   = 6'd19;
  localparam logic [KIND_W-1:0] TK_MKDIR     = 6'd20;
  localparam logic [KIND_W-1:0] TK_LEN       = 6'd21;
  localparam logic [KIND_W-1:0] TK_EQEQ      = 6'd22;
  localparam logic [KIND_W-1:0] TK_GE        = 6'd23;
  localparam logic [KIND_W-1:0] TK_LE        = 6'd24;
  localparam logic [KIND_W-1:0] TK_NE        = 6'd25;
  localparam logic [KIND_W-1:0] TK_SEMI      = 6'd26;
  localparam logic [KIND_W-1:0] TK_LPAREN    = 6'd27;
  localparam logic [KIND_W-1:0] TK_RPAREN    = 6'd28;
  localparam logic [KIND_W-1:0] TK_LBRACE    = 6'd29;
  localparam logic [KIND_W-1:0] TK_RBRACE    = 6'd30;
  localparam logic [KIND_W-1:0] TK_LT        = 6'd31;
  localparam logic [KIND_W-1:0] TK_GT        = 6'd32;
  localparam logic [KIND_W-1:0] TK_PLUS      = 6'd33;
  localparam logic [KIND_W-1:0] TK_MINUS     = 6'd34;
  localparam logic [KIND_W-1:0] TK_STAR      = 6'd35;
  localparam logic [KIND_W-1:0] TK_SLASH     = 6'd36;
  localparam logic [KIND_W-1:0] TK_ASSIGN    = 6'd37;
  localparam logic [KIND_W-1:0] TK_UNTERM    = 6'd38;

  // character codes
  localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CH_W-1:0] CH_NL     = 8'h0A;
  localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CH_W-1:0] CH_SP     = " ";
  localparam logic [CH_W-1:0] CH_HASH   = "#";
  localparam logic [CH_W-1:0] CH_QUOTE  = "\"";
  localparam logic [CH_W-1:0] CH_USCORE = "_";
  localparam logic [CH_W-1:0] CH_EQ     = "=";
  localparam logic [CH_W-1:0] CH_LT     = "<";
  localparam logic [CH_W-1:0] CH_GT     = ">";
  localparam logic [CH_W-1:0] CH_BANG   = "!";
  localparam logic [CH_W-1:0] CH_SEMI   = ";";
  localparam logic [CH_W-1:0] CH_LPAREN = "(";
  localparam logic [CH_W-1:0] CH_RPAREN = ")";
  localparam logic [CH_W-1:0] CH_LBRACE = "{";
  localparam logic [CH_W-1:0] CH_RBRACE = "}";
  localparam logic [CH_W-1:0] CH_PLUS   = "+";
  localparam logic [CH_W-1:0] CH_MINUS  = "-";
  localparam logic [CH_W-1:0] CH_STAR   = "*";
  localparam logic [CH_W-1:0] CH_SLASH  = "/";
  localparam logic [CH_W-1:0] CH_LC_A   = "a";
  localparam logic [CH_W-1:0] CH_LC_Z   = "z";
  localparam logic [CH_W-1:0] CH_UC_A   = "A";
  localparam logic [CH_W-1:0] CH_UC_Z   = "Z";
  localparam logic [CH_W-1:0] CH_D0     = "0";
  localparam logic [CH_W-1:0] CH_D9     = "9";

  // scan modes
  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_STRING,
    MODE_COMMENT,
    MODE_HELD
  } mode_e;

  // one result word
  typedef struct packed {
    logic                is_text;
    logic [KIND_W-1:0]   kind;
    logic [CH_W-1:0]     chr;
    logic [TLINE_W-1:0]  line;
    logic                last;
  } res_t;

  // keyword table, spellings right-aligned as string literals
  localparam int KW_NUM     = 33;
  localparam int KW_MAX_LEN = 14;

  localparam logic [KW_MAX_LEN*CH_W-1:0] KW_SPELL [KW_NUM] = '{
    "metablhth", "set", "gia", "for", "an", "if", "eos", "to",
    "ari8mo", "num", "mhnhma", "str", "print", "printent", "println",
    "perimene", "wait", "ka8arise", "clear", "sbyse", "remove",
    {"diabase", "_arxeio"}, {"read", "_file"}, "diabase", "read", "telosprograma",
    "endprogram", "treje", "execute", "neosfakelos", "mkdir", "mhkos", "len"
  };

  localparam int KW_LEN [KW_NUM] = '{
    9, 3, 3, 3, 2, 2, 3, 2, 6, 3, 6, 3, 5, 8, 7, 8, 4, 8, 5, 5, 6,
    14, 9, 7, 4, 13, 10, 5, 7, 11, 5, 5, 3
  };

  localparam logic [KIND_W-1:0] KW_KIND [KW_NUM] = '{
    TK_SET, TK_SET, TK_FOR, TK_FOR, TK_IF, TK_IF, TK_TO, TK_TO,
    TK_NUM, TK_NUM, TK_STR, TK_STR, TK_PRINT, TK_PRINTLN, TK_PRINTLN,
    TK_WAIT, TK_WAIT, TK_CLEAR, TK_CLEAR, TK_REMOVE, TK_REMOVE,
    TK_LOAD_FILE, TK_LOAD_FILE, TK_READ, TK_READ, TK_ENDPROG, TK_ENDPROG,
    TK_EXECUTE, TK_EXECUTE, TK_MKDIR, TK_MKDIR, TK_LEN, TK_LEN
  };

  // character classes
  function automatic logic is_alpha(logic [CH_W-1:0] c);
    return c inside {[CH_LC_A:CH_LC_Z], [CH_UC_A:CH_UC_Z]};
  endfunction

  function automatic logic is_digit(logic [CH_W-1:0] c);
    return c inside {[CH_D0:CH_D9]};
  endfunction

  function automatic logic is_space(logic [CH_W-1:0] c);
    return c inside {CH_SP, [CH_TAB:CH_CR]};
  endfunction

  // operator that stands alone
  function automatic logic [KIND_W-1:0] single_kind(logic [CH_W-1:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      CH_SEMI:   k = TK_SEMI;
      CH_LPAREN: k = TK_LPAREN;
      CH_RPAREN: k = TK_RPAREN;
      CH_LBRACE: k = TK_LBRACE;
      CH_RBRACE: k = TK_RBRACE;
      CH_LT:     k = TK_LT;
      CH_GT:     k = TK_GT;
      CH_PLUS:   k = TK_PLUS;
      CH_MINUS:  k = TK_MINUS;
      CH_STAR:   k = TK_STAR;
      CH_SLASH:  k = TK_SLASH;
      CH_EQ:     k = TK_ASSIGN;
      default:   k = TK_BAD;
    endcase
    return k;
  endfunction

  // held operator followed by '='
  function automatic logic [KIND_W-1:0] double_kind(logic [CH_W-1:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      CH_EQ:   k = TK_EQEQ;
      CH_GT:   k = TK_GE;
      CH_LT:   k = TK_LE;
      default: k = TK_NE;
    endcase
    return k;
  endfunction

endpackage

// File: rtl/core/sl_kw_match.sv
// ----------------------------------------------------------------------------
// sl_kw_match: keyword matcher
// compares the buffered word against every keyword spelling in parallel
// ----------------------------------------------------------------------------
module sl_kw_match #(
  parameter int LEN_W = 5
) (
  input  logic [sl_pkg::KW_MAX_LEN*sl_pkg::CH_W-1:0] word_i,
  input  logic [LEN_W-1:0]                           len_i,
  output logic [sl_pkg::KIND_W-1:0]                  kind_o
);

  logic hit;
  logic found;

  // one comparator per table entry, first hit wins
  always_comb begin
    kind_o = sl_pkg::TK_IDENT;
    found  = 1'b0;
    hit    = 1'b0;
    for (int e = 0; e < sl_pkg::KW_NUM; e++) begin
      hit = (int'(len_i) == sl_pkg::KW_LEN[e]);
      for (int i = 0; i < sl_pkg::KW_MAX_LEN; i++) begin
        if (i < sl_pkg::KW_LEN[e]) begin
          if (word_i[sl_pkg::CH_W*i +: sl_pkg::CH_W] !=
              sl_pkg::KW_SPELL[e][sl_pkg::CH_W*((sl_pkg::KW_LEN[e] + sl_pkg::KW_MAX_LEN
                                  - 1 - i) % sl_pkg::KW_MAX_LEN) +: sl_pkg::CH_W]) begin
            hit = 1'b0;
          end
        end
      end
      if (hit && !found) begin
        kind_o = sl_pkg::KW_KIND[e];
        found  = 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/sl_scan.sv
// ----------------------------------------------------------------------------
// sl_scan: scanner state and per-character decode
// holds mode, line count and word buffer, and forms up to two result words
// ----------------------------------------------------------------------------
module sl_scan #(
  parameter int MAX_WORD  = sl_pkg::MAX_WORD_DEF,
  parameter int LINE_BITS = sl_pkg::LINE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     proc_i,
  input  logic [sl_pkg::CH_W-1:0]  ch_i,
  input  logic [sl_pkg::CFG_W-1:0] first_line_i,
  output logic [1:0]               push_o,
  output sl_pkg::res_t             res0_o,
  output sl_pkg::res_t             res1_o
);

  localparam int LEN_W = $clog2(MAX_WORD + 2);
  localparam int IDX_W = $clog2(MAX_WORD);
  localparam int CW    = (LINE_BITS > sl_pkg::CFG_W) ? LINE_BITS : sl_pkg::CFG_W;
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [CW-1:0]        TLINE_MAX = CW'({sl_pkg::TLINE_W{1'b1}});

  // decode of a character seen between tokens
  typedef struct packed {
    sl_pkg::mode_e             mode;
    logic                      emit;
    logic                      is_text;
    logic [sl_pkg::KIND_W-1:0] kind;
    logic [sl_pkg::CH_W-1:0]   chr;
    logic                      line_inc;
    logic                      tok;
    logic                      word;
    logic                      held;
    logic                      eof;
  } start_t;

  sl_pkg::mode_e              mode_q, mode_d;
  logic [LINE_BITS-1:0]       line_q, line_d;
  logic [LINE_BITS-1:0]       sline_q, sline_d;
  logic [LEN_W-1:0]           wlen_q, wlen_d;
  logic [sl_pkg::CH_W-1:0]    held_q, held_d;
  logic [sl_pkg::CH_W-1:0]    wbuf_q [MAX_WORD];

  logic [LINE_BITS-1:0]       first_line;
  logic [CW-1:0]              fl_ext;
  logic [LINE_BITS-1:0]       line_inc;
  logic [sl_pkg::KW_MAX_LEN*sl_pkg::CH_W-1:0] word;
  logic [sl_pkg::KIND_W-1:0]  kw_kind;
  start_t                     st;
  logic                       do_start;
  logic                       ea_vld;
  sl_pkg::res_t               ea;
  sl_pkg::res_t               st_res;
  logic                       buf_we;
  logic [IDX_W-1:0]           buf_idx;

  function automatic logic [sl_pkg::TLINE_W-1:0] clip(logic [LINE_BITS-1:0] v);
    logic [CW-1:0] ve;
    ve = CW'(v);
    if (ve > TLINE_MAX) begin
      return {sl_pkg::TLINE_W{1'b1}};
    end
    return ve[sl_pkg::TLINE_W-1:0];
  endfunction

  // register value clamped to the line range
  assign fl_ext     = CW'(first_line_i);
  assign first_line = (fl_ext > CW'(LINE_MAX)) ? LINE_MAX : LINE_BITS'(fl_ext);

  // saturating line increment
  assign line_inc = (line_q == LINE_MAX) ? line_q : line_q + LINE_BITS'(1);

  // keyword lookup over the first buffer entries
  for (genvar g = 0; g < sl_pkg::KW_MAX_LEN; g++) begin : g_word
    assign word[sl_pkg::CH_W*g +: sl_pkg::CH_W] = wbuf_q[g];
  end

  sl_kw_match #(
    .LEN_W (LEN_W)
  ) u_kw_match (
    .word_i (word),
    .len_i  (wlen_q),
    .kind_o (kw_kind)
  );

  // start decode
  always_comb begin
    st         = '0;
    st.mode    = sl_pkg::MODE_IDLE;
    st.kind    = sl_pkg::TK_EOF;
    if (ch_i == sl_pkg::CH_NUL) begin
      st.emit = 1'b1;
      st.eof  = 1'b1;
    end else if (sl_pkg::is_space(ch_i)) begin
      st.line_inc = (ch_i == sl_pkg::CH_NL);
    end else if (ch_i == sl_pkg::CH_HASH) begin
      st.mode = sl_pkg::MODE_COMMENT;
    end else if (sl_pkg::is_alpha(ch_i)) begin
      st.mode    = sl_pkg::MODE_IDENT;
      st.tok     = 1'b1;
      st.word    = 1'b1;
      st.emit    = 1'b1;
      st.is_text = 1'b1;
      st.kind    = sl_pkg::TK_IDENT;
      st.chr     = ch_i;
    end else if (sl_pkg::is_digit(ch_i)) begin
      st.mode    = sl_pkg::MODE_NUMBER;
      st.tok     = 1'b1;
      st.emit    = 1'b1;
      st.is_text = 1'b1;
      st.kind    = sl_pkg::TK_NUMBER;
      st.chr     = ch_i;
    end else if (ch_i == sl_pkg::CH_QUOTE) begin
      st.mode = sl_pkg::MODE_STRING;
      st.tok  = 1'b1;
    end else if (ch_i inside {sl_pkg::CH_EQ, sl_pkg::CH_LT, sl_pkg::CH_GT,
                              sl_pkg::CH_BANG}) begin
      st.mode = sl_pkg::MODE_HELD;
      st.tok  = 1'b1;
      st.held = 1'b1;
    end else begin
      st.emit = 1'b1;
      st.kind = sl_pkg::single_kind(ch_i);
    end
  end

  // step decode: first result of the current mode, and whether to restart
  always_comb begin
    do_start   = 1'b0;
    ea_vld     = 1'b0;
    ea         = '0;
    ea.line    = clip(sline_q);
    buf_we     = 1'b0;
    buf_idx    = '0;
    case (mode_q)
      sl_pkg::MODE_HELD: begin
        ea_vld = 1'b1;
        if (ch_i == sl_pkg::CH_EQ) begin
          ea.kind = sl_pkg::double_kind(held_q);
        end else begin
          ea.kind  = sl_pkg::single_kind(held_q);
          do_start = 1'b1;
        end
      end
      sl_pkg::MODE_IDENT: begin
        ea_vld = 1'b1;
        if (sl_pkg::is_alpha(ch_i) || sl_pkg::is_digit(ch_i) ||
            ch_i == sl_pkg::CH_USCORE) begin
          ea.is_text = 1'b1;
          ea.kind    = sl_pkg::TK_IDENT;
          ea.chr     = ch_i;
          buf_we     = (wlen_q < LEN_W'(MAX_WORD));
          buf_idx    = wlen_q[IDX_W-1:0];
        end else begin
          ea.kind  = kw_kind;
          do_start = 1'b1;
        end
      end
      sl_pkg::MODE_NUMBER: begin
        ea_vld  = 1'b1;
        ea.kind = sl_pkg::TK_NUMBER;
        if (sl_pkg::is_digit(ch_i)) begin
          ea.is_text = 1'b1;
          ea.chr     = ch_i;
        end else begin
          do_start = 1'b1;
        end
      end
      sl_pkg::MODE_STRING: begin
        ea_vld = 1'b1;
        if (ch_i == sl_pkg::CH_QUOTE) begin
          ea.kind = sl_pkg::TK_STRING;
        end else if (ch_i == sl_pkg::CH_NUL) begin
          ea.kind  = sl_pkg::TK_UNTERM;
          do_start = 1'b1;
        end else begin
          ea.is_text = 1'b1;
          ea.kind    = sl_pkg::TK_STRING;
          ea.chr     = ch_i;
        end
      end
      sl_pkg::MODE_COMMENT: begin
        do_start = (ch_i == sl_pkg::CH_NL) || (ch_i == sl_pkg::CH_NUL);
      end
      default: begin
        do_start = 1'b1;
      end
    endcase
    if (do_start && st.word) begin
      buf_we  = 1'b1;
      buf_idx = '0;
    end
  end

  // next state
  always_comb begin
    mode_d  = mode_q;
    line_d  = line_q;
    sline_d = sline_q;
    wlen_d  = wlen_q;
    held_d  = held_q;
    case (mode_q)
      sl_pkg::MODE_HELD: begin
        held_d = '0;
        mode_d = sl_pkg::MODE_IDLE;
      end
      sl_pkg::MODE_IDENT: begin
        if (do_start) begin
          wlen_d = '0;
        end else if (wlen_q <= LEN_W'(MAX_WORD)) begin
          wlen_d = wlen_q + LEN_W'(1);
        end
      end
      sl_pkg::MODE_STRING: begin
        if (ch_i == sl_pkg::CH_QUOTE) begin
          mode_d = sl_pkg::MODE_IDLE;
        end else if (ch_i == sl_pkg::CH_NL) begin
          line_d = line_inc;
        end
      end
      default: begin
      end
    endcase
    if (do_start) begin
      mode_d = st.mode;
      if (st.line_inc) begin
        line_d = line_inc;
      end
      if (st.tok) begin
        sline_d = line_q;
      end
      if (st.word) begin
        wlen_d = LEN_W'(1);
      end
      if (st.held) begin
        held_d = ch_i;
      end
      if (st.eof) begin
        line_d = first_line;
        held_d = '0;
        wlen_d = '0;
      end
    end
  end

  // result words
  always_comb begin
    st_res         = '0;
    st_res.is_text = st.is_text;
    st_res.kind    = st.kind;
    st_res.chr     = st.chr;
    st_res.line    = clip(line_q);
    push_o[0]      = proc_i & (ea_vld | (do_start & st.emit));
    push_o[1]      = proc_i & ea_vld & do_start & st.emit;
    res0_o         = ea_vld ? ea : st_res;
    res0_o.last    = !(ea_vld & do_start & st.emit);
    res1_o         = st_res;
    res1_o.last    = 1'b1;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= sl_pkg::MODE_IDLE;
      line_q  <= LINE_BITS'(1);
      sline_q <= '0;
      wlen_q  <= '0;
      held_q  <= '0;
    end else if (proc_i) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      sline_q <= sline_d;
      wlen_q  <= wlen_d;
      held_q  <= held_d;
    end
  end

  // word buffer, no reset
  always_ff @(posedge clk_i) begin
    if (proc_i && buf_we) begin
      wbuf_q[buf_idx] <= ch_i;
    end
  end

endmodule

// File: rtl/core/sl_res_fifo.sv
// ----------------------------------------------------------------------------
// sl_res_fifo: result queue
// takes up to two result words a cycle and hands out one, head registered
// ----------------------------------------------------------------------------
module sl_res_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [1:0]   push_i,
  input  sl_pkg::res_t res0_i,
  input  sl_pkg::res_t res1_i,
  output logic         room_o,
  output logic         valid_o,
  input  logic         stall_i,
  output sl_pkg::res_t head_o
);

  sl_pkg::res_t                  mem_q [sl_pkg::RQ_DEPTH];
  logic [sl_pkg::RQ_PTR_W-1:0]   wr_q, wr_d;
  logic [sl_pkg::RQ_PTR_W-1:0]   rd_q, rd_d;
  logic [sl_pkg::RQ_CNT_W-1:0]   cnt_q, cnt_d;
  logic                          pop;

  // room for two words, counted without this cycle's pop
  assign room_o  = (cnt_q <= sl_pkg::RQ_CNT_W'(sl_pkg::RQ_DEPTH - 2));
  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o & !stall_i;
  assign head_o  = mem_q[rd_q];

  // pointer and fill update
  always_comb begin
    wr_d  = wr_q + sl_pkg::RQ_PTR_W'(push_i[0]) + sl_pkg::RQ_PTR_W'(push_i[1]);
    rd_d  = rd_q + sl_pkg::RQ_PTR_W'(pop);
    cnt_d = cnt_q + sl_pkg::RQ_CNT_W'(push_i[0]) + sl_pkg::RQ_CNT_W'(push_i[1])
            - sl_pkg::RQ_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push_i[0]) begin
      mem_q[wr_q] <= res0_i;
    end
    if (push_i[1]) begin
      mem_q[wr_q + sl_pkg::RQ_PTR_W'(1)] <= res1_i;
    end
  end

endmodule

// File: rtl/core/script_lexer.sv
// ----------------------------------------------------------------------------
// script_lexer: character-serial lexical analyser
// skips blanks and comments, emits literal text and tokens with line numbers
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-------------------------------
//  input    | in        | in_valid_i / in_stall_o  | ch_i
//  result   | out       | out_valid_o / out_stall_i| is_text_o token_kind_o
//           |           |                          | text_char_o token_line_o last_o
//  config   | in        | cfg_valid_i / cfg_ready_o| cfg_data_i (first line number)
//
//  one character is taken every cycle while the queue has room; one that causes two
//  words hands them out in turn, so sustained rate is one result word per cycle while
//  out_stall_i is low, set by the single output port and the four-word result queue.
//  a character is held in the input register, its first result then in the queue.
//  reset clears all control state, the line count starts at 1; no clearing pass.
//  in_stall_o rises while a character waits and the queue has under two free words.
// ----------------------------------------------------------------------------
module script_lexer #(
  parameter int MAX_WORD  = sl_pkg::MAX_WORD_DEF,
  parameter int LINE_BITS = sl_pkg::LINE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // source characters
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [sl_pkg::CH_W-1:0]    ch_i,
  // results
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       is_text_o,
  output logic [sl_pkg::KIND_W-1:0]  token_kind_o,
  output logic [sl_pkg::CH_W-1:0]    text_char_o,
  output logic [sl_pkg::TLINE_W-1:0] token_line_o,
  output logic                       last_o,
  // configuration
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [sl_pkg::CFG_W-1:0]   cfg_data_i
);

  logic                     in_vld_q;
  logic [sl_pkg::CH_W-1:0]  ch_q;
  logic [sl_pkg::CFG_W-1:0] first_line_q;
  logic                     room;
  logic                     proc;
  logic                     accept;
  logic [1:0]               push;
  sl_pkg::res_t             res0;
  sl_pkg::res_t             res1;
  sl_pkg::res_t             head;

  // input handshake
  assign proc        = in_vld_q & room;
  assign in_stall_o  = in_vld_q & !room;
  assign accept      = in_valid_i & !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (proc) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q <= ch_i;
    end
  end

  // first line number register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_line_q <= sl_pkg::CFG_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      first_line_q <= cfg_data_i;
    end
  end

  sl_scan #(
    .MAX_WORD  (MAX_WORD),
    .LINE_BITS (LINE_BITS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .proc_i       (proc),
    .ch_i         (ch_q),
    .first_line_i (first_line_q),
    .push_o       (push),
    .res0_o       (res0),
    .res1_o       (res1)
  );

  sl_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res0_i  (res0),
    .res1_i  (res1),
    .room_o  (room),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .head_o  (head)
  );

  // result fields
  assign is_text_o    = head.is_text;
  assign token_kind_o = head.kind;
  assign text_char_o  = head.chr;
  assign token_line_o = head.line;
  assign last_o       = head.last;

endmodule

// File: rtl/core/sl_checker.sv
// ----------------------------------------------------------------------------
// sl_checker: port checks of the script lexer
// watches the result channel for held words and consistent fields
// ----------------------------------------------------------------------------
module sl_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       is_text_o,
  input logic [sl_pkg::KIND_W-1:0]  token_kind_o,
  input logic [sl_pkg::CH_W-1:0]    text_char_o,
  input logic [sl_pkg::TLINE_W-1:0] token_line_o,
  input logic                       last_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(is_text_o) &&
      $stable(token_kind_o) && $stable(text_char_o) && $stable(token_line_o) &&
      $stable(last_o)))
    else $error("result word changed while stalled");

  // text words only belong to identifiers, numbers and strings
  a_text_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_text_o) |-> (token_kind_o == sl_pkg::TK_IDENT ||
      token_kind_o == sl_pkg::TK_NUMBER || token_kind_o == sl_pkg::TK_STRING))
    else $error("text word with a non-literal kind");

  // token words carry no character
  a_token_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_text_o) |-> (text_char_o == '0))
    else $error("token word with a character");

  // kind code within the defined range
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (token_kind_o <= sl_pkg::TK_UNTERM))
    else $error("token kind out of range");

endmodule

bind script_lexer sl_checker u_sl_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: script lexer regression
// feeds source characters through a driver with random gaps, predicts every
// text word and token in a behavioural lexer of its own, and checks the
// result words field by field under random and long receiver stalls
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_WORD      = sl_pkg::MAX_WORD_DEF;
  localparam int KW_COUNT      = sl_pkg::KW_NUM;
  localparam int OP_COUNT      = 17;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 64;
  localparam int HOLD_AFTER    = 150;
  localparam int PHASE_CHARS   = 262;
  localparam int RUN_LIMIT_NS  = 2_000_000;

  localparam logic [sl_pkg::CH_W-1:0] CH_VT = 8'h0B;
  localparam logic [sl_pkg::CH_W-1:0] CH_FF = 8'h0C;

  // clock, reset and block ports
  logic                       clk_i        = 1'b0;
  logic                       rst_ni       = 1'b0;
  logic                       in_valid_i   = 1'b0;
  logic                       in_stall_o;
  logic [sl_pkg::CH_W-1:0]    ch_i         = '0;
  logic                       out_valid_o;
  logic                       out_stall_i  = 1'b0;
  logic                       is_text_o;
  logic [sl_pkg::KIND_W-1:0]  token_kind_o;
  logic [sl_pkg::CH_W-1:0]    text_char_o;
  logic [sl_pkg::TLINE_W-1:0] token_line_o;
  logic                       last_o;
  logic                       cfg_valid_i  = 1'b0;
  logic                       cfg_ready_o;
  logic [sl_pkg::CFG_W-1:0]   cfg_data_i   = '0;

  // keyword spellings and the token each one gives
  string kw_text [KW_COUNT] = '{
    "metablhth", "set", "gia", "for", "an", "if", "eos", "to",
    "ari8mo", "num", "mhnhma", "str", "print", "printent", "println",
    "perimene", "wait", "ka8arise", "clear", "sbyse", "remove",
    {"diabase", "_arxeio"}, {"read", "_file"}, "diabase", "read", "telosprograma",
    "endprogram", "treje", "execute", "neosfakelos", "mkdir", "mhkos", "len"
  };
  logic [sl_pkg::KIND_W-1:0] kw_code [KW_COUNT] = '{
    sl_pkg::TK_SET, sl_pkg::TK_SET, sl_pkg::TK_FOR, sl_pkg::TK_FOR,
    sl_pkg::TK_IF, sl_pkg::TK_IF, sl_pkg::TK_TO, sl_pkg::TK_TO,
    sl_pkg::TK_NUM, sl_pkg::TK_NUM, sl_pkg::TK_STR, sl_pkg::TK_STR,
    sl_pkg::TK_PRINT, sl_pkg::TK_PRINTLN, sl_pkg::TK_PRINTLN,
    sl_pkg::TK_WAIT, sl_pkg::TK_WAIT, sl_pkg::TK_CLEAR, sl_pkg::TK_CLEAR,
    sl_pkg::TK_REMOVE, sl_pkg::TK_REMOVE,
    sl_pkg::TK_LOAD_FILE, sl_pkg::TK_LOAD_FILE, sl_pkg::TK_READ, sl_pkg::TK_READ,
    sl_pkg::TK_ENDPROG, sl_pkg::TK_ENDPROG,
    sl_pkg::TK_EXECUTE, sl_pkg::TK_EXECUTE, sl_pkg::TK_MKDIR, sl_pkg::TK_MKDIR,
    sl_pkg::TK_LEN, sl_pkg::TK_LEN
  };
  string op_text [OP_COUNT] = '{
    "==", ">=", "<=", "!=", ";", "(", ")", "{", "}", "<", ">", "+", "-",
    "*", "/", "=", "!"
  };
  logic [sl_pkg::CH_W-1:0] blank_set [6] = '{
    sl_pkg::CH_SP, sl_pkg::CH_TAB, sl_pkg::CH_NL, CH_VT, CH_FF, sl_pkg::CH_CR
  };

  // lexer state as predicted
  sl_pkg::mode_e              scan_state     = sl_pkg::MODE_IDLE;
  logic [sl_pkg::CFG_W-1:0]   first_line_cfg = 16'd1;
  logic [sl_pkg::TLINE_W-1:0] cur_line       = 16'd1;
  logic [sl_pkg::TLINE_W-1:0] tok_line       = '0;
  logic [sl_pkg::CH_W-1:0]    word_chars [MAX_WORD];
  int                         word_len       = 0;
  logic [sl_pkg::CH_W-1:0]    held_char      = '0;

  // words of the current character, then the store of words still due
  sl_pkg::res_t step_words [2];
  int           step_n;
  sl_pkg::res_t expected_words [$];

  // source characters waiting for the driver
  logic [sl_pkg::CH_W-1:0] source_chars [$];
  int queued_chars   = 0;
  int accepted_chars = 0;

  // idling controls
  int   tx_gap    = 0;
  int   rx_wait   = 0;
  logic tx_burst  = 1'b0;
  logic rx_burst  = 1'b0;
  logic rx_hold   = 1'b0;
  int   mismatches = 0;

  script_lexer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .ch_i         (ch_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .is_text_o    (is_text_o),
    .token_kind_o (token_kind_o),
    .text_char_o  (text_char_o),
    .token_line_o (token_line_o),
    .last_o       (last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s is %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // behavioural lexer
  // ---------------------------------------------------------------------------

  function automatic logic letter_char(input logic [sl_pkg::CH_W-1:0] c);
    return (c >= sl_pkg::CH_LC_A && c <= sl_pkg::CH_LC_Z) ||
           (c >= sl_pkg::CH_UC_A && c <= sl_pkg::CH_UC_Z);
  endfunction

  function automatic logic digit_char(input logic [sl_pkg::CH_W-1:0] c);
    return c >= sl_pkg::CH_D0 && c <= sl_pkg::CH_D9;
  endfunction

  function automatic logic [sl_pkg::KIND_W-1:0] lone_op_kind(
    input logic [sl_pkg::CH_W-1:0] c);
    logic [sl_pkg::KIND_W-1:0] k;
    case (c)
      sl_pkg::CH_SEMI:   k = sl_pkg::TK_SEMI;
      sl_pkg::CH_LPAREN: k = sl_pkg::TK_LPAREN;
      sl_pkg::CH_RPAREN: k = sl_pkg::TK_RPAREN;
      sl_pkg::CH_LBRACE: k = sl_pkg::TK_LBRACE;
      sl_pkg::CH_RBRACE: k = sl_pkg::TK_RBRACE;
      sl_pkg::CH_LT:     k = sl_pkg::TK_LT;
      sl_pkg::CH_GT:     k = sl_pkg::TK_GT;
      sl_pkg::CH_PLUS:   k = sl_pkg::TK_PLUS;
      sl_pkg::CH_MINUS:  k = sl_pkg::TK_MINUS;
      sl_pkg::CH_STAR:   k = sl_pkg::TK_STAR;
      sl_pkg::CH_SLASH:  k = sl_pkg::TK_SLASH;
      sl_pkg::CH_EQ:     k = sl_pkg::TK_ASSIGN;
      default:           k = sl_pkg::TK_BAD;
    endcase
    return k;
  endfunction

  task automatic emit_word(input logic txt, input logic [sl_pkg::KIND_W-1:0] k,
                           input logic [sl_pkg::CH_W-1:0] c,
                           input logic [sl_pkg::TLINE_W-1:0] ln);
    sl_pkg::res_t w;
    w.is_text = txt;
    w.kind    = k;
    w.chr     = c;
    w.line    = ln;
    w.last    = 1'b0;
    if (step_n < 2) begin
      step_words[step_n] = w;
      step_n++;
    end
  endtask

  // line count saturates at its top value
  task automatic bump_line();
    if (cur_line != 16'hFFFF)
      cur_line = cur_line + 16'd1;
  endtask

  // eof token, then the line count reloads from the register
  task automatic end_source();
    emit_word(1'b0, sl_pkg::TK_EOF, '0, cur_line);
    cur_line   = first_line_cfg;
    scan_state = sl_pkg::MODE_IDLE;
    held_char  = '0;
    word_len   = 0;
  endtask

  // identifier bytes past the buffer are counted once more, never stored
  task automatic store_letter(input logic [sl_pkg::CH_W-1:0] c);
    if (word_len < MAX_WORD)
      word_chars[word_len] = c;
    if (word_len <= MAX_WORD)
      word_len++;
  endtask

  // a character seen between tokens
  task automatic begin_token(input logic [sl_pkg::CH_W-1:0] c);
    scan_state = sl_pkg::MODE_IDLE;
    if (c == sl_pkg::CH_NUL) begin
      end_source();
    end else if (c == sl_pkg::CH_SP || (c >= sl_pkg::CH_TAB && c <= sl_pkg::CH_CR)) begin
      if (c == sl_pkg::CH_NL)
        bump_line();
    end else if (c == sl_pkg::CH_HASH) begin
      scan_state = sl_pkg::MODE_COMMENT;
    end else if (letter_char(c)) begin
      scan_state = sl_pkg::MODE_IDENT;
      tok_line   = cur_line;
      word_len   = 0;
      store_letter(c);
      emit_word(1'b1, sl_pkg::TK_IDENT, c, tok_line);
    end else if (digit_char(c)) begin
      scan_state = sl_pkg::MODE_NUMBER;
      tok_line   = cur_line;
      emit_word(1'b1, sl_pkg::TK_NUMBER, c, tok_line);
    end else if (c == sl_pkg::CH_QUOTE) begin
      scan_state = sl_pkg::MODE_STRING;
      tok_line   = cur_line;
    end else if (c == sl_pkg::CH_EQ || c == sl_pkg::CH_LT || c == sl_pkg::CH_GT ||
                 c == sl_pkg::CH_BANG) begin
      scan_state = sl_pkg::MODE_HELD;
      held_char  = c;
      tok_line   = cur_line;
    end else begin
      emit_word(1'b0, lone_op_kind(c), '0, cur_line);
    end
  endtask

  // one accepted character: advance the lexer and queue the words it gives
  task automatic lex_step(input logic [sl_pkg::CH_W-1:0] c);
    logic [sl_pkg::KIND_W-1:0] k;
    int i, j;
    bit same;
    step_n = 0;
    case (scan_state)
      sl_pkg::MODE_HELD: begin
        if (c == sl_pkg::CH_EQ) begin
          case (held_char)
            sl_pkg::CH_EQ: k = sl_pkg::TK_EQEQ;
            sl_pkg::CH_GT: k = sl_pkg::TK_GE;
            sl_pkg::CH_LT: k = sl_pkg::TK_LE;
            default:       k = sl_pkg::TK_NE;
          endcase
          emit_word(1'b0, k, '0, tok_line);
          held_char  = '0;
          scan_state = sl_pkg::MODE_IDLE;
        end else begin
          emit_word(1'b0, lone_op_kind(held_char), '0, tok_line);
          held_char = '0;
          begin_token(c);
        end
      end
      sl_pkg::MODE_IDENT: begin
        if (letter_char(c) || digit_char(c) || c == sl_pkg::CH_USCORE) begin
          store_letter(c);
          emit_word(1'b1, sl_pkg::TK_IDENT, c, tok_line);
        end else begin
          // keyword match only while the whole word fits the buffer
          k = sl_pkg::TK_IDENT;
          if (word_len <= MAX_WORD) begin
            for (i = 0; i < KW_COUNT; i++) begin
              if (kw_text[i].len() == word_len) begin
                same = 1'b1;
                for (j = 0; j < word_len; j++)
                  if (kw_text[i].getc(j) != word_chars[j]) same = 1'b0;
                if (same) k = kw_code[i];
              end
            end
          end
          emit_word(1'b0, k, '0, tok_line);
          word_len = 0;
          begin_token(c);
        end
      end
      sl_pkg::MODE_NUMBER: begin
        if (digit_char(c)) begin
          emit_word(1'b1, sl_pkg::TK_NUMBER, c, tok_line);
        end else begin
          emit_word(1'b0, sl_pkg::TK_NUMBER, '0, tok_line);
          begin_token(c);
        end
      end
      sl_pkg::MODE_STRING: begin
        if (c == sl_pkg::CH_QUOTE) begin
          emit_word(1'b0, sl_pkg::TK_STRING, '0, tok_line);
          scan_state = sl_pkg::MODE_IDLE;
        end else if (c == sl_pkg::CH_NUL) begin
          emit_word(1'b0, sl_pkg::TK_UNTERM, '0, tok_line);
          end_source();
        end else begin
          if (c == sl_pkg::CH_NL)
            bump_line();
          emit_word(1'b1, sl_pkg::TK_STRING, c, tok_line);
        end
      end
      sl_pkg::MODE_COMMENT: begin
        if (c == sl_pkg::CH_NL) begin
          bump_line();
          scan_state = sl_pkg::MODE_IDLE;
        end else if (c == sl_pkg::CH_NUL) begin
          end_source();
        end
      end
      default: begin
        begin_token(c);
      end
    endcase
    if (step_n > 0)
      step_words[step_n-1].last = 1'b1;
    for (i = 0; i < step_n; i++)
      expected_words.push_back(step_words[i]);
  endtask

  // ---------------------------------------------------------------------------
  // driver: one source character per word, random gap after each
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      ch_i       <= '0;
      tx_gap     <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        lex_step(ch_i);
        accepted_chars <= accepted_chars + 1;
      end
      if (in_valid_i && in_stall_o) begin
        // stalled word stays on the port
      end else if (tx_gap != 0) begin
        in_valid_i <= 1'b0;
        tx_gap     <= tx_gap - 1;
      end else if (source_chars.size() != 0) begin
        in_valid_i <= 1'b1;
        ch_i       <= source_chars.pop_front();
        tx_gap     <= tx_burst ? 0 : $urandom_range(0, 3);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compare each result word with the oldest one due
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : result_check
    sl_pkg::res_t got;
    sl_pkg::res_t want;
    int wait_n;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait     <= 0;
    end else begin
      wait_n = rx_wait;
      if (out_valid_o && !out_stall_i) begin
        got = {is_text_o, token_kind_o, text_char_o, token_line_o, last_o};
        if (expected_words.size() == 0) begin
          report_mismatch("result word with none due, kind", int'(got.kind), 0);
        end else begin
          want = expected_words.pop_front();
          if (got.is_text !== want.is_text)
            report_mismatch("is_text", int'(got.is_text), int'(want.is_text));
          if (got.kind !== want.kind)
            report_mismatch("token_kind", int'(got.kind), int'(want.kind));
          if (got.chr !== want.chr)
            report_mismatch("text_char", int'(got.chr), int'(want.chr));
          if (got.line !== want.line)
            report_mismatch("token_line", int'(got.line), int'(want.line));
          if (got.last !== want.last)
            report_mismatch("last", int'(got.last), int'(want.last));
        end
        wait_n = rx_burst ? 0 : $urandom_range(0, 3);
      end else if (wait_n != 0) begin
        wait_n = wait_n - 1;
      end
      rx_wait     <= wait_n;
      out_stall_i <= rx_hold || (wait_n != 0);
    end
  end

  // long receiver hold-off while the source keeps coming
  initial begin : backpressure
    wait (accepted_chars >= HOLD_AFTER);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic put_char(input logic [sl_pkg::CH_W-1:0] c);
    source_chars.push_back(c);
    queued_chars++;
  endtask

  task automatic put_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++)
      put_char(s[i]);
  endtask

  function automatic logic [sl_pkg::CH_W-1:0] any_letter();
    if ($urandom_range(0, 1) != 0)
      return sl_pkg::CH_LC_A + sl_pkg::CH_W'($urandom_range(0, 25));
    return sl_pkg::CH_UC_A + sl_pkg::CH_W'($urandom_range(0, 25));
  endfunction

  // one token of a plausible script, or now and then a stray byte
  task automatic put_token();
    logic [sl_pkg::CH_W-1:0] c;
    int pick, n;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      put_text(kw_text[$urandom_range(0, KW_COUNT-1)]);
    end else if (pick < 40) begin
      // identifier, now and then longer than the buffer
      put_char(any_letter());
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 22) : $urandom_range(0, 6);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0:       c = sl_pkg::CH_D0 + sl_pkg::CH_W'($urandom_range(0, 9));
          1:       c = sl_pkg::CH_USCORE;
          default: c = any_letter();
        endcase
        put_char(c);
      end
    end else if (pick < 52) begin
      repeat ($urandom_range(1, 5))
        put_char(sl_pkg::CH_D0 + sl_pkg::CH_W'($urandom_range(0, 9)));
    end else if (pick < 62) begin
      // quoted string, any byte but the end byte or a quote inside, rarely left open
      put_char(sl_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 6)) begin
        c = sl_pkg::CH_W'($urandom_range(1, 255));
        if (c == sl_pkg::CH_QUOTE || $urandom_range(0, 5) == 0)
          c = sl_pkg::CH_NL;
        put_char(c);
      end
      if ($urandom_range(0, 19) != 0)
        put_char(sl_pkg::CH_QUOTE);
    end else if (pick < 80) begin
      put_text(op_text[$urandom_range(0, OP_COUNT-1)]);
    end else if (pick < 88) begin
      // comment, usually closed by a newline
      put_char(sl_pkg::CH_HASH);
      repeat ($urandom_range(0, 8)) begin
        c = sl_pkg::CH_W'($urandom_range(1, 255));
        if (c == sl_pkg::CH_NL)
          c = sl_pkg::CH_SP;
        put_char(c);
      end
      if ($urandom_range(0, 9) != 0)
        put_char(sl_pkg::CH_NL);
    end else if (pick < 94) begin
      put_char(blank_set[$urandom_range(0, 5)]);
    end else begin
      put_char(sl_pkg::CH_W'($urandom_range(1, 255)));
    end
    // mostly a separator, sometimes tokens run together
    if ($urandom_range(0, 9) < 7)
      put_char(($urandom_range(0, 3) == 0) ? sl_pkg::CH_NL : sl_pkg::CH_SP);
  endtask

  // one source of some length, closed by the end byte
  task automatic put_source(input int goal);
    int first;
    first = queued_chars;
    while (queued_chars - first < goal)
      put_token();
    put_char(sl_pkg::CH_NUL);
  endtask

  // wait until every character is in and every word out, then a margin
  task automatic drain();
    int n;
    n = 0;
    while ((accepted_chars != queued_chars || expected_words.size() != 0) &&
           n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (accepted_chars != queued_chars)
      report_mismatch("source words taken", accepted_chars, queued_chars);
    if (expected_words.size() != 0) begin
      report_mismatch("result words still due", expected_words.size(), 0);
      expected_words.delete();
    end
  endtask

  task automatic write_first_line(input logic [sl_pkg::CFG_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    first_line_cfg = v;
  endtask

  initial begin : sequence_main
    logic [sl_pkg::CFG_W-1:0] start_line;
    int k;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every operator, joined pairs, lone bang, stray bytes at both extremes
    put_text("_==>=<=!=!<>;(){}+-*/=");
    put_char(8'hFF);
    put_char(sl_pkg::CH_NUL);
    drain();

    // line count runs into saturation, open string and comment at the end
    write_first_line(16'hFFFE);
    put_char(sl_pkg::CH_NUL);
    put_text("#c\n\n\"u\n");
    put_char(sl_pkg::CH_NUL);
    put_text("#z");
    put_char(sl_pkg::CH_NUL);
    drain();

    // random scripts under several first line numbers and idling mixes
    for (k = 0; k < 5; k++) begin
      case (k)
        0:       start_line = 16'd0;
        1:       start_line = 16'hFFFF;
        4:       start_line = 16'd1;
        default: start_line = sl_pkg::CFG_W'($urandom_range(0, 65535));
      endcase
      tx_burst <= (k == 1 || k == 2) ? 1'b1 : (k == 4) ? 1'($urandom_range(0, 1)) : 1'b0;
      rx_burst <= (k == 1 || k == 3) ? 1'b1 : (k == 4) ? 1'($urandom_range(0, 1)) : 1'b0;
      write_first_line(start_line);
      // empty source so the new line number takes effect at once
      put_char(sl_pkg::CH_NUL);
      while (queued_chars < 40 + (k + 1) * PHASE_CHARS)
        put_source($urandom_range(10, 80));
      drain();
    end

    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // hard stop if the run hangs
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/sl_pkg.sv
rtl/core/sl_kw_match.sv
rtl/core/sl_scan.sv
rtl/core/sl_res_fifo.sv
rtl/core/script_lexer.sv
rtl/core/sl_checker.sv
tb/testbench.sv
